>>> rtl/rbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbg_pkg
// Shared types and constants of the renko brick generator: request and
// response payloads, trend codes, move codes and the controller interface.
// ----------------------------------------------------------------------------
package rbg_pkg;

   localparam int TimeW  = 63;
   localparam int PriceW = 32;
   localparam int SizeW  = 31;

   typedef enum logic [1:0] {
      TR_NONE = 2'd0,
      TR_UP   = 2'd1,
      TR_DOWN = 2'd2
   } trend_type;

   typedef enum logic [2:0] {
      MV_NONE     = 3'd0,
      MV_UP       = 3'd1,
      MV_DOWN     = 3'd2,
      MV_REV_DOWN = 3'd3,
      MV_REV_UP   = 3'd4
   } move_type;

   typedef struct packed {
      logic        [TimeW-1:0]  timestamp;
      logic signed [PriceW-1:0] price;
   } req_type;

   typedef struct packed {
      logic        [TimeW-1:0]  brick_time;
      logic signed [PriceW-1:0] brick_open;
      logic signed [PriceW-1:0] brick_high;
      logic signed [PriceW-1:0] brick_low;
      logic signed [PriceW-1:0] brick_close;
      logic                     last_brick;
      logic                     truncated;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic load_base;
      logic calc_diff;
      logic step;
      logic push;
      logic push_last;
      logic push_trunc;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic size_zero;
      logic move_hit;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/renko_brick_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_brick_generator
// Renko bricks from a stream of closing prices with a configurable brick size.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_type (timestamp, price)
//   rsp_      out        rsp_valid / rsp_stall   rsp_type (one brick)
//   csr_      in         csr_wr_en               brick size, 31 bits
//
// First request after reset, or any request at brick size zero: taken in idle
// with no brick loop. Later request: runs through the difference / brick step
// loop, which any response stall can hold.
// A brick is held until the next step decides last and truncated flags.
// Reset clears base, trend, started and sets brick size to 1.
// Response stalls hold the brick loop; requests stall in reset and while an
// item is open.
// ----------------------------------------------------------------------------
module renko_brick_generator
   import rbg_pkg::*;
#(
   parameter int MAX_BRICKS = 16,
   parameter int PRICE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [SizeW-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   rbg_ctrl #(
      .MAX_BRICKS(MAX_BRICKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rbg_datapath #(
      .PRICE_BITS(PRICE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

>>> rtl/rbg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbg_ctrl
// Sequencer of the brick generator: takes a request, alternates between
// difference and brick steps, counts bricks and schedules output pushes.
// ----------------------------------------------------------------------------
module rbg_ctrl
   import rbg_pkg::*;
#(
   parameter int MAX_BRICKS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam int CntW = $clog2(MAX_BRICKS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIFF = 3'b010,
      ST_STEP = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            pend_valid_ff, pend_valid_in;
   logic            hit;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign hit       = stat.move_hit && (cnt_ff != CntW'(MAX_BRICKS));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!stat.started) begin
                  cmd.load_base = 1'b1;
               end else if (!stat.size_zero) begin
                  cnt_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_STEP;
         end
         ST_STEP: begin
            if (hit) begin
               if (!pend_valid_ff || stat.out_free) begin
                  cmd.step      = 1'b1;
                  cmd.push      = pend_valid_ff;
                  cnt_in        = cnt_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  state_in      = ST_DIFF;
               end
            end else if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.push       = 1'b1;
               cmd.push_last  = 1'b1;
               cmd.push_trunc = stat.move_hit;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

>>> rtl/rbg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbg_datapath
// Base price, trend and brick size registers, price difference, move
// decision, pending brick and the output register.
// ----------------------------------------------------------------------------
module rbg_datapath
   import rbg_pkg::*;
#(
   parameter int PRICE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [SizeW-1:0] csr_wr_data,
   input  cmd_type          cmd,
   output stat_type         stat,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int BaseW = (PRICE_BITS > PriceW) ? PriceW + 1 : PRICE_BITS;
   localparam int DiffW = (BaseW + 1 > PriceW + 2) ? BaseW + 1 : PriceW + 2;

   logic signed [BaseW-1:0]  base_ff;
   logic signed [BaseW-1:0]  price_ff;
   logic        [TimeW-1:0]  time_ff;
   trend_type                trend_ff;
   logic                     started_ff;
   logic        [SizeW-1:0]  size_ff;
   logic signed [DiffW-1:0]  diff_ff;
   rsp_type                  pend_ff;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   logic signed [BaseW-1:0]  req_price;
   logic signed [DiffW-1:0]  base_x, price_x, size_x, size2_x;
   logic signed [DiffW-1:0]  off_open, off_close, open_x, close_x;
   move_type                 move;
   logic                     rise;
   rsp_type                  push_data;

   generate
      if (PRICE_BITS > PriceW) begin : g_wide
         assign req_price = signed'({1'b0, req_data.price});
      end else begin : g_narrow
         assign req_price = req_data.price[BaseW-1:0];
      end
   endgenerate

   assign base_x  = {{(DiffW - BaseW){base_ff[BaseW-1]}}, base_ff};
   assign price_x = {{(DiffW - BaseW){price_ff[BaseW-1]}}, price_ff};
   assign size_x  = signed'({{(DiffW - SizeW){1'b0}}, size_ff});
   assign size2_x = size_x <<< 1;

   always_comb begin
      move = MV_NONE;
      if ((trend_ff != TR_DOWN) && (diff_ff >= size_x)) begin
         move = MV_UP;
      end else if ((trend_ff != TR_UP) && (diff_ff <= -size_x)) begin
         move = MV_DOWN;
      end else if ((trend_ff == TR_UP) && (diff_ff <= -size2_x)) begin
         move = MV_REV_DOWN;
      end else if ((trend_ff == TR_DOWN) && (diff_ff >= size2_x)) begin
         move = MV_REV_UP;
      end
   end

   always_comb begin
      off_open  = '0;
      off_close = '0;
      rise      = 1'b0;
      case (move)
         MV_UP: begin
            off_close = size_x;
            rise      = 1'b1;
         end
         MV_DOWN: begin
            off_close = -size_x;
         end
         MV_REV_DOWN: begin
            off_open  = -size_x;
            off_close = -size2_x;
         end
         MV_REV_UP: begin
            off_open  = size_x;
            off_close = size2_x;
            rise      = 1'b1;
         end
         default: begin
            off_open  = '0;
            off_close = '0;
         end
      endcase
   end

   assign open_x  = base_x + off_open;
   assign close_x = base_x + off_close;

   always_comb begin
      push_data            = pend_ff;
      push_data.last_brick = cmd.push_last;
      push_data.truncated  = cmd.push_trunc;
   end

   assign stat.started   = started_ff;
   assign stat.size_zero = (size_ff == '0);
   assign stat.move_hit  = (move != MV_NONE);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         trend_ff     <= TR_NONE;
         started_ff   <= 1'b0;
         size_ff      <= SizeW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (cmd.load_base) begin
            base_ff    <= req_price;
            started_ff <= 1'b1;
         end else if (cmd.step) begin
            base_ff  <= close_x[BaseW-1:0];
            trend_ff <= rise ? TR_UP : TR_DOWN;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff  <= req_data.timestamp;
         price_ff <= req_price;
      end
      if (cmd.calc_diff) begin
         diff_ff <= price_x - base_x;
      end
      if (cmd.step) begin
         pend_ff.brick_time  <= time_ff;
         pend_ff.brick_open  <= open_x[PriceW-1:0];
         pend_ff.brick_high  <= rise ? close_x[PriceW-1:0] : open_x[PriceW-1:0];
         pend_ff.brick_low   <= rise ? open_x[PriceW-1:0] : close_x[PriceW-1:0];
         pend_ff.brick_close <= close_x[PriceW-1:0];
         pend_ff.last_brick  <= 1'b0;
         pend_ff.truncated   <= 1'b0;
      end
      if (cmd.push) begin
         rsp_ff <= push_data;
      end
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the renko brick generator. The bench sends closing
// prices with random idle gaps and random response stalls. It predicts every
// brick from its own copy of base price, trend and brick size, and compares
// each brick against the oldest prediction, field by field. Directed tests
// cover the first request, zero brick size, reversals, the per-request brick
// limit and price extremes. Random price walks then run at several brick
// sizes.
// ----------------------------------------------------------------------------
module testbench;
   import rbg_pkg::*;

   localparam int MaxBricks   = 16;
   localparam int DrainCycles = 40;
   localparam int QuietLimit  = 1000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [SizeW-1:0] csr_wr_data;

   // brick predictor state
   logic [SizeW-1:0] brick_size_q;
   longint           base_price_q;
   trend_type        trend_q;
   bit               started_q;
   rsp_type          expected_bricks[$];

   int gap_max;
   int stall_max;
   int errors;
   int requests_sent;
   int bricks_checked;
   int truncated_seen;
   int quiet_cycles;

   renko_brick_generator #(
      .MAX_BRICKS(MaxBricks),
      .PRICE_BITS(PriceW)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic move_type brick_move(longint price, longint size);
      if (trend_q != TR_DOWN && price >= base_price_q + size) return MV_UP;
      if (trend_q != TR_UP && price <= base_price_q - size) return MV_DOWN;
      if (trend_q == TR_UP && price <= base_price_q - 2 * size) return MV_REV_DOWN;
      if (trend_q == TR_DOWN && price >= base_price_q + 2 * size) return MV_REV_UP;
      return MV_NONE;
   endfunction

   function automatic void predict_bricks(req_type item);
      longint   price;
      longint   size;
      longint   open_price;
      longint   close_price;
      int       count;
      bit       rise;
      move_type move;
      rsp_type  brick;
      price = longint'($signed(item.price));
      size  = longint'(brick_size_q);
      count = 0;
      brick = '0;
      if (!started_q) begin
         base_price_q = price;
         started_q    = 1'b1;
         return;
      end
      if (size == 0) return;
      move = brick_move(price, size);
      while (count < MaxBricks && move != MV_NONE) begin
         if (count > 0) expected_bricks = {expected_bricks, brick};
         case (move)
            MV_UP: begin
               open_price = base_price_q; close_price = base_price_q + size; rise = 1'b1;
            end
            MV_DOWN: begin
               open_price = base_price_q; close_price = base_price_q - size; rise = 1'b0;
            end
            MV_REV_DOWN: begin
               open_price  = base_price_q - size;
               close_price = base_price_q - 2 * size;
               rise        = 1'b0;
            end
            default: begin
               open_price  = base_price_q + size;
               close_price = base_price_q + 2 * size;
               rise        = 1'b1;
            end
         endcase
         brick.brick_time  = item.timestamp;
         brick.brick_open  = open_price[PriceW-1:0];
         brick.brick_high  = rise ? close_price[PriceW-1:0] : open_price[PriceW-1:0];
         brick.brick_low   = rise ? open_price[PriceW-1:0] : close_price[PriceW-1:0];
         brick.brick_close = close_price[PriceW-1:0];
         brick.last_brick  = 1'b0;
         brick.truncated   = 1'b0;
         base_price_q = close_price;
         trend_q      = rise ? TR_UP : TR_DOWN;
         count++;
         move = brick_move(price, size);
      end
      if (count > 0) begin
         brick.last_brick = 1'b1;
         brick.truncated  = (move != MV_NONE);
         expected_bricks  = {expected_bricks, brick};
      end
   endfunction

   function automatic logic signed [PriceW-1:0] clamp_price(longint value);
      if (value > 64'sd2147483647) return 32'sh7fffffff;
      if (value < -64'sd2147483648) return 32'sh80000000;
      return value[PriceW-1:0];
   endfunction

   function automatic logic [TimeW-1:0] random_stamp();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[TimeW-1:0];
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic send_request(input logic [TimeW-1:0] stamp, input longint price);
      int      gap;
      req_type item;
      item.timestamp = stamp;
      item.price     = clamp_price(price);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_bricks(item);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_offset(input longint offset);
      send_request(random_stamp(), base_price_q + offset);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bricks.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_brick_size(input logic [SizeW-1:0] size);
      wait_idle();
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= size;
      brick_size_q  = size;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_first_request_and_zero_size();
      gap_max   = 0;
      stall_max = 0;
      set_brick_size('0);
      send_request('0, 1000);
      send_request({TimeW{1'b1}}, 2147483647);
      send_request(random_stamp(), -64'sd2147483648);
   endtask

   task automatic test_unit_bricks();
      set_brick_size(SizeW'(1));
      gap_max   = 15;
      stall_max = 15;
      send_offset(1);
      send_offset(3);
      send_offset(-1);
      send_offset(-2);
      send_offset(-1);
      send_offset(1);
      send_offset(2);
      send_offset(0);
   endtask

   task automatic test_brick_limit();
      gap_max   = 0;
      stall_max = 0;
      send_offset(MaxBricks);
      send_offset(MaxBricks + 1);
      send_request(random_stamp(), -64'sd2147483648);
   endtask

   task automatic test_price_extremes();
      set_brick_size({SizeW{1'b1}});
      gap_max   = 3;
      stall_max = 3;
      send_request(random_stamp(), 2147483647);
      send_request(random_stamp(), -64'sd2147483648);
      send_request(random_stamp(), 2147483647);
      send_request(random_stamp(), -64'sd2147483648);
      send_request(random_stamp(), 0);
   endtask

   task automatic random_phase(input logic [SizeW-1:0] size, input int count,
                               input int gaps, input int stalls, input bit pause);
      longint      step;
      longint      span;
      longint      offset;
      logic [63:0] bits;
      int          i;
      set_brick_size(size);
      gap_max   = gaps;
      stall_max = stalls;
      step = (size == 0) ? 1 : longint'(size);
      for (i = 0; i < count; i++) begin
         // hold off until the pipeline has emptied
         if (pause && i == count / 2) begin
            req_valid <= 1'b0;
            while (expected_bricks.size() != 0) @(negedge clock);
         end
         if ($urandom_range(9, 0) == 0) begin
            send_request(random_stamp(), longint'($signed($urandom)));
         end else begin
            span   = (($urandom_range(7, 0) == 0) ? 20 : 3) * step;
            bits   = {$urandom, $urandom};
            offset = longint'(bits % (2 * span + 1)) - span;
            send_offset(offset);
         end
      end
   endtask

   task automatic test_random_walk();
      random_phase(SizeW'(1), 30, 15, 15, 1'b0);
      random_phase(SizeW'($urandom_range(9, 2)), 30, 0, 0, 1'b1);
      random_phase(SizeW'($urandom_range(100000, 10)), 30, 15, 0, 1'b0);
      random_phase('0, 10, 0, 15, 1'b0);
      random_phase(SizeW'($urandom_range(32'h7fffffff, 32'h40000000)), 25, 6, 6, 1'b0);
      random_phase(SizeW'($urandom), 25, 15, 15, 1'b1);
   endtask

   // response side stalls
   initial begin : response_stall
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = (stall_max == 0) ? 0 : $urandom_range(stall_max, 0);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : check_bricks
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bricks.size() == 0) begin
            errors++;
            $display("%0t: unexpected brick, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_bricks.pop_front();
            bricks_checked++;
            if (want.truncated) truncated_seen++;
            check_field("brick_time", want.brick_time, rsp_data.brick_time);
            check_field("brick_open", want.brick_open, rsp_data.brick_open);
            check_field("brick_high", want.brick_high, rsp_data.brick_high);
            check_field("brick_low", want.brick_low, rsp_data.brick_low);
            check_field("brick_close", want.brick_close, rsp_data.brick_close);
            check_field("last_brick", want.last_brick, rsp_data.last_brick);
            check_field("truncated", want.truncated, rsp_data.truncated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      brick_size_q = 1;
      base_price_q = 0;
      trend_q      = TR_NONE;
      started_q    = 1'b0;
      gap_max      = 0;
      stall_max    = 0;
      errors       = 0;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_first_request_and_zero_size();
      test_unit_bricks();
      test_brick_limit();
      test_price_extremes();
      test_random_walk();
      wait_idle();
      $display("requests sent: %0d, bricks checked: %0d, truncated bricks: %0d",
               requests_sent, bricks_checked, truncated_seen);
      $display("brick sizes zero, one, small, medium, large and maximum; errors: %0d",
               errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
